// ----- sv/ordered_point_list_engine_macros.svh -----
// Assertion macros for the ordered point list engine.
// Used by ordered_point_list_engine.sv; expects clk and rst_n in scope.
`ifndef ORDERED_POINT_LIST_ENGINE_MACROS_SVH
`define ORDERED_POINT_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define OPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/opl_pkg.sv -----
// Shared types and constants for the ordered point list engine.
// No dependencies; imported by opl_cell and ordered_point_list_engine.
package opl_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int COORD_BITS_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int PT_W   = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ----- sv/opl_cell.sv -----
// One list slot of the ordered point list engine: holds one point and
// shifts it to or from its neighbors. Depends on opl_pkg.
module opl_cell #(
  parameter int IDX        = 0,
  parameter int CW         = 8,
  parameter int COORD_BITS = 32
) (
  input  logic                   clk,
  input  opl_pkg::cell_ctrl_t    ctrl,
  input  logic [CW-1:0]          pos,
  input  logic [COORD_BITS-1:0]  new_x,
  input  logic [COORD_BITS-1:0]  new_y,
  input  logic [COORD_BITS-1:0]  left_x,
  input  logic [COORD_BITS-1:0]  left_y,
  input  logic [COORD_BITS-1:0]  right_x,
  input  logic [COORD_BITS-1:0]  right_y,
  output logic [COORD_BITS-1:0]  x,
  output logic [COORD_BITS-1:0]  y,
  output logic [COORD_BITS-1:0]  sel_x,
  output logic [COORD_BITS-1:0]  sel_y
);
  import opl_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;
  logic                  hit;

  assign hit = (pos == MY_IDX);

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (ctrl.ins) begin
      if (MY_IDX > pos) begin
        x_nxt = left_x;
        y_nxt = left_y;
      end else if (hit) begin
        x_nxt = new_x;
        y_nxt = new_y;
      end
    end else if (ctrl.rem) begin
      if (MY_IDX >= pos) begin
        x_nxt = right_x;
        y_nxt = right_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign x     = x_r;
  assign y     = y_r;
  assign sel_x = hit ? x_r : '0;
  assign sel_y = hit ? y_r : '0;

endmodule

// ----- sv/ordered_point_list_engine.sv -----
// Top level of the ordered point list engine: command register, count,
// row of opl_cell slots and result register. Depends on opl_pkg, opl_cell.
//
// Usage:
//   A request (in_cmd, in_position, in_point_x, in_point_y) is taken at a
//   rising edge where start is high and busy is low. busy is registered at that
//   edge and is high while the request executes.
//   Each request gives one result. out_valid is high for exactly one cycle,
//   registered from busy, with out_status, out_read_x,
//   out_read_y and out_count. The receiver cannot stall the result.
//   A new request is taken only after the previous one has executed. Insert
//   and remove shift the slots at and above the position in the execute cycle;
//   a read selects one slot through the row's select-and-OR path in that same cycle.
//   Reset (rst_n low, synchronous) empties the list and drops any request
//   in flight. Slot contents are not cleared; only slots below the count
//   are ever read.
//   Points keep their low COORD_BITS bits and read back sign-extended.
`include "ordered_point_list_engine_macros.svh"
module ordered_point_list_engine #(
  parameter int DEPTH      = opl_pkg::DEPTH_DEF,
  parameter int COORD_BITS = opl_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [opl_pkg::CMD_W-1:0]           in_cmd,
  input  logic [opl_pkg::POS_W-1:0]           in_position,
  input  logic signed [opl_pkg::PT_W-1:0]     in_point_x,
  input  logic signed [opl_pkg::PT_W-1:0]     in_point_y,
  output logic                                out_valid,
  output logic [opl_pkg::STAT_W-1:0]          out_status,
  output logic signed [opl_pkg::PT_W-1:0]     out_read_x,
  output logic signed [opl_pkg::PT_W-1:0]     out_read_y,
  output logic [opl_pkg::CNT_W-1:0]           out_count
);
  import opl_pkg::*;

  localparam int HW = $clog2(DEPTH + 1);
  localparam int CW = (HW > POS_W) ? HW : POS_W;
  localparam logic [HW-1:0] FULL_CNT = HW'(DEPTH);

  logic                  busy_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [POS_W-1:0]      pos_r;
  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic [HW-1:0]         held_r, held_nxt;

  logic                  out_valid_r;
  status_t               out_status_r, out_status_nxt;
  logic [PT_W-1:0]       out_read_x_r, out_read_x_nxt;
  logic [PT_W-1:0]       out_read_y_r, out_read_y_nxt;
  logic [CNT_W-1:0]      out_count_r;

  cell_ctrl_t            ctrl;
  logic [CW-1:0]         eff_pos;
  logic [COORD_BITS-1:0] rd_x, rd_y;

  logic [COORD_BITS-1:0] cx [DEPTH];
  logic [COORD_BITS-1:0] cy [DEPTH];
  logic [COORD_BITS-1:0] sx [DEPTH];
  logic [COORD_BITS-1:0] sy [DEPTH];

  assign eff_pos = (cmd_r == CMD_APPEND) ? CW'(held_r) : CW'(pos_r);

  always_comb begin
    rd_x = '0;
    rd_y = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_x = rd_x | sx[i];
      rd_y = rd_y | sy[i];
    end
  end

  always_comb begin
    ctrl           = '0;
    held_nxt       = held_r;
    out_status_nxt = ST_DONE;
    out_read_x_nxt = '0;
    out_read_y_nxt = '0;
    if (busy_r) begin
      unique case (cmd_r) inside
        CMD_APPEND, CMD_INSERT: begin
          if (eff_pos > CW'(held_r)) begin
            out_status_nxt = ST_INVALID;
          end else if (held_r == FULL_CNT) begin
            out_status_nxt = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            held_nxt = held_r + HW'(1);
          end
        end
        CMD_REMOVE: begin
          if (eff_pos >= CW'(held_r)) begin
            out_status_nxt = ST_INVALID;
          end else begin
            ctrl.rem = 1'b1;
            held_nxt = held_r - HW'(1);
          end
        end
        CMD_READ: begin
          if (eff_pos >= CW'(held_r)) begin
            out_status_nxt = ST_INVALID;
          end else begin
            out_read_x_nxt = PT_W'(signed'(rd_x));
            out_read_y_nxt = PT_W'(signed'(rd_y));
          end
        end
        CMD_CLEAR: begin
          held_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [COORD_BITS-1:0] lx, ly, rx, ry;
    if (i == 0) begin : g_first
      assign lx = px_r;
      assign ly = py_r;
    end else begin : g_mid_l
      assign lx = cx[i-1];
      assign ly = cy[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rx = cx[i];
      assign ry = cy[i];
    end else begin : g_mid_r
      assign rx = cx[i+1];
      assign ry = cy[i+1];
    end
    opl_cell #(
      .IDX        (i),
      .CW         (CW),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .pos     (eff_pos),
      .new_x   (px_r),
      .new_y   (py_r),
      .left_x  (lx),
      .left_y  (ly),
      .right_x (rx),
      .right_y (ry),
      .x       (cx[i]),
      .y       (cy[i]),
      .sel_x   (sx[i]),
      .sel_y   (sy[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= start && !busy_r;
      held_r      <= held_nxt;
      out_valid_r <= busy_r;
    end
    if (start && !busy_r) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      px_r  <= in_point_x[COORD_BITS-1:0];
      py_r  <= in_point_y[COORD_BITS-1:0];
    end
    if (busy_r) begin
      out_status_r <= out_status_nxt;
      out_read_x_r <= out_read_x_nxt;
      out_read_y_r <= out_read_y_nxt;
      out_count_r  <= CNT_W'(held_nxt);
    end
  end

  assign busy       = busy_r;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_read_x = out_read_x_r;
  assign out_read_y = out_read_y_r;
  assign out_count  = out_count_r;

  `OPL_ASSERT_NEXT(a_accept_runs, start && !busy_r, busy_r, "request did not execute")
  `OPL_ASSERT_NEXT(a_exec_result, busy_r, out_valid_r, "execute gave no result")
  `OPL_ASSERT_NEXT(a_reject_keeps, busy_r && out_status_nxt != ST_DONE,
                   held_r == $past(held_r), "rejected request changed the count")
  `OPL_ASSERT_NOW(a_count_bound, 1'b1, held_r <= FULL_CNT, "count above depth")
  `OPL_ASSERT_NOW(a_reject_zero, out_valid_r && out_status_r != ST_DONE,
                  out_read_x_r == '0 && out_read_y_r == '0, "rejected result has data")

endmodule
